@@ rtl/core/orpf_pkg.sv @@
// Package for the overwriting page ring FIFO.
// Request codes, register indexes and the byte mask helper; no dependencies.
package orpf_pkg;

    localparam int DATA_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    typedef logic [3:0] t_req;

    localparam t_req REQ_WRITE        = 4'd0;
    localparam t_req REQ_WRITE_PART   = 4'd1;
    localparam t_req REQ_READ_OLDEST  = 4'd2;
    localparam t_req REQ_POP_NEWEST   = 4'd3;
    localparam t_req REQ_PEEK_NEWEST  = 4'd4;
    localparam t_req REQ_PEEK_OFFSET  = 4'd5;
    localparam t_req REQ_READ_N       = 4'd6;
    localparam t_req REQ_TRIM         = 4'd7;
    localparam t_req REQ_FLUSH        = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2  = 2'd1;

    // longest run a read-n request may emit
    localparam logic [4:0] MAX_RUN = 5'd16;

    // low n bytes set, n of 8 or more sets all
    function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < n) m[8*b +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

@@ rtl/core/orpf_if.sv @@
// Valid/ready channel interfaces: request, response and config write.
// Depends on orpf_pkg for widths.
interface orpf_req_if;
    import orpf_pkg::*;
    logic              valid;
    logic              ready;
    logic [3:0]        req_type;
    logic [DATA_W-1:0] page_data;
    logic [3:0]        write_length;
    logic [4:0]        amount;
    modport source (output valid, req_type, page_data, write_length, amount, input ready);
    modport sink   (input valid, req_type, page_data, write_length, amount, output ready);
endinterface

interface orpf_rsp_if;
    import orpf_pkg::*;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [DATA_W-1:0] page_data_out;
    logic [7:0]        byte_total;
    logic [4:0]        pages_stored;
    logic [4:0]        pages_free;
    logic              last;
    modport source (output valid, ok, page_data_out, byte_total, pages_stored, pages_free,
                    last, input ready);
    modport sink   (input valid, ok, page_data_out, byte_total, pages_stored, pages_free,
                    last, output ready);
endinterface

interface orpf_cfg_if;
    import orpf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/orpf_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module orpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/core/overwriting_page_ring_fifo.sv @@
// Top level of the overwriting page ring FIFO: request FSM, pointers, output register.
// Depends on orpf_pkg, orpf_if.sv and orpf_ram.
//
// Usage:
//  i_req carries one request item (req_type, page_data, write_length, amount);
//  o_rsp returns result items (ok, page_data_out, byte_total, pages_stored,
//  pages_free, last). Every request gives one result with last set, except
//  read-n, which gives one result per page read, last on the final one.
//  i_cfg writes page_bytes (index 0) and page_count_log2 (index 1); it is
//  always ready. Writing page_count_log2 clears both pointers. Write config
//  only while no request is in flight.
// Timing:
//  A request is taken in the idle state, reads the page store in the read
//  step, and its result is registered in the write-back step; read-n goes
//  back through both steps for every further page. A new request is taken
//  only once the last one is through its write-back step.
//  The output register lets the next request enter while a result waits.
// Stall: a stalled result holds the FSM in its write-back step; nothing is
//  dropped. Reset clears the pointers and sets the registers to 8 bytes and
//  log2 pages 4; the page store holds no reset value.
module overwriting_page_ring_fifo #(
    parameter int MAX_PAGES      = 16,
    parameter int PAGE_BYTES_MAX = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    orpf_req_if.sink   i_req,
    orpf_rsp_if.source o_rsp,
    orpf_cfg_if.sink   i_cfg
);
    import orpf_pkg::*;

    // largest usable log2 page count, pointer and address widths
    localparam int LG_MAX = $clog2(MAX_PAGES + 1) - 1;
    localparam int PW     = LG_MAX + 1;
    localparam int DEPTH  = 1 << LG_MAX;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW     = 8 * PAGE_BYTES_MAX;
    localparam int CMPW   = (PW > 5) ? PW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0]        r_state, n_state;
    t_req              r_req;
    logic [DW-1:0]     r_data;
    logic [3:0]        r_wlen;
    logic [4:0]        r_amount;
    logic [4:0]        r_run_n;
    logic [4:0]        r_run_left, n_run_left;
    logic [PW-1:0]     r_rp, n_rp;
    logic [PW-1:0]     r_wp, n_wp;
    logic [3:0]        r_page_bytes;
    logic [2:0]        r_page_lg;

    logic              r_out_valid;
    logic              r_ok, n_ok;
    logic [DATA_W-1:0] r_dout, n_dout;
    logic [7:0]        r_total, n_total;
    logic [4:0]        r_stored, r_free;
    logic              r_last, n_last;

    logic [3:0]        pb_eff;
    logic [3:0]        lg_eff;
    logic [PW-1:0]     piu;
    logic [AW-1:0]     slot_mask;
    logic [PW-1:0]     cnt;
    logic [CMPW-1:0]   cnt_c, amt_c, amt_in_c, run_c;
    logic [4:0]        run_n;
    logic [PW-1:0]     rd_ptr;
    logic [AW-1:0]     ram_addr;
    logic              ram_rd_en, ram_wr_en;
    logic [DW-1:0]     ram_q, ram_wdata, rd_page, wmask;
    logic [3:0]        wlen_eff;
    logic [PW-1:0]     n_cnt, n_free;
    logic [CMPW-1:0]   n_cnt_c, n_free_c;
    logic              out_free, wb_go, done, req_acc;

    // effective page size and count
    always_comb begin
        if (r_page_bytes == 4'd0) pb_eff = 4'd1;
        else if (r_page_bytes > 4'(PAGE_BYTES_MAX)) pb_eff = 4'(PAGE_BYTES_MAX);
        else pb_eff = r_page_bytes;
        if ({1'b0, r_page_lg} > 4'(LG_MAX)) lg_eff = 4'(LG_MAX);
        else lg_eff = {1'b0, r_page_lg};
    end

    assign piu       = PW'(1) << lg_eff;
    assign slot_mask = AW'(piu - PW'(1));
    assign cnt       = r_wp - r_rp;
    assign cnt_c     = CMPW'(cnt);
    assign amt_c     = CMPW'(r_amount);
    assign amt_in_c  = CMPW'(i_req.amount);

    // read-n run length, fixed when the request is taken
    always_comb begin
        run_c = (cnt_c < amt_in_c) ? cnt_c : amt_in_c;
        if (run_c > CMPW'(MAX_RUN)) run_c = CMPW'(MAX_RUN);
    end
    assign run_n = run_c[4:0];

    // page slot touched by the request; same in both steps
    always_comb begin
        case (r_req)
            REQ_WRITE, REQ_WRITE_PART:        rd_ptr = r_wp;
            REQ_POP_NEWEST, REQ_PEEK_NEWEST:  rd_ptr = r_wp - PW'(1);
            REQ_PEEK_OFFSET:                  rd_ptr = r_wp - PW'(r_amount);
            default:                          rd_ptr = r_rp;
        endcase
    end
    assign ram_addr = rd_ptr[AW-1:0] & slot_mask;

    assign req_acc  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign wb_go    = (r_state == S_WB) && out_free;
    assign ram_rd_en = (r_state == S_RD);

    assign rd_page = ram_q & DW'(byte_mask(pb_eff));

    // merge for writes: bytes past the length keep their old content
    always_comb begin
        if (r_req == REQ_WRITE) wlen_eff = pb_eff;
        else if (r_wlen > pb_eff) wlen_eff = pb_eff;
        else wlen_eff = r_wlen;
    end
    assign wmask     = DW'(byte_mask(wlen_eff));
    assign ram_wdata = (ram_q & ~wmask) | (r_data & wmask);
    assign ram_wr_en = wb_go && (r_req == REQ_WRITE || r_req == REQ_WRITE_PART);

    // write-back step: pointer update and result
    always_comb begin
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_ok       = 1'b0;
        n_dout     = '0;
        n_total    = 8'd0;
        n_last     = 1'b1;
        n_run_left = r_run_left;
        done       = 1'b1;
        case (r_req)
            REQ_WRITE, REQ_WRITE_PART: begin
                n_ok = 1'b1;
                if (cnt == piu) n_rp = r_rp + PW'(1);   // full: drop oldest
                n_wp = r_wp + PW'(1);
            end
            REQ_READ_OLDEST: begin
                if (cnt != '0) begin
                    n_ok   = 1'b1;
                    n_dout = DATA_W'(rd_page);
                    n_rp   = r_rp + PW'(1);
                end
            end
            REQ_POP_NEWEST: begin
                if (cnt != '0) begin
                    n_ok   = 1'b1;
                    n_dout = DATA_W'(rd_page);
                    n_wp   = r_wp - PW'(1);
                end
            end
            REQ_PEEK_NEWEST: begin
                if (cnt != '0) begin
                    n_ok   = 1'b1;
                    n_dout = DATA_W'(rd_page);
                end
            end
            REQ_PEEK_OFFSET: begin
                // offset zero is rejected, as is one beyond the stored pages
                if (r_amount != 5'd0 && amt_c <= cnt_c) begin
                    n_ok   = 1'b1;
                    n_dout = DATA_W'(rd_page);
                end
            end
            REQ_READ_N: begin
                if (r_run_n != 5'd0) begin
                    n_ok       = 1'b1;
                    n_dout     = DATA_W'(rd_page);
                    n_rp       = r_rp + PW'(1);
                    n_run_left = r_run_left - 5'd1;
                    n_last     = (r_run_left == 5'd1);
                    done       = n_last;
                    if (n_last) n_total = 8'(r_run_n) * 8'(pb_eff);
                end
            end
            REQ_TRIM: begin
                n_ok = 1'b1;
                if (cnt_c > amt_c) n_rp = r_wp - PW'(r_amount);
            end
            REQ_FLUSH: begin
                n_ok = 1'b1;
                n_rp = r_wp;
            end
            default: ;
        endcase
    end

    assign n_cnt    = n_wp - n_rp;
    assign n_free   = piu - n_cnt;
    assign n_cnt_c  = CMPW'(n_cnt);
    assign n_free_c = CMPW'(n_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (req_acc) n_state = S_RD;
            S_RD:    n_state = S_WB;
            S_WB:    if (wb_go) n_state = done ? S_IDLE : S_RD;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rp         <= '0;
            r_wp         <= '0;
            r_page_bytes <= 4'd8;
            r_page_lg    <= 3'd4;
            r_out_valid  <= 1'b0;
            r_run_left   <= 5'd0;
        end else begin
            r_state <= n_state;
            if (wb_go) begin
                r_rp       <= n_rp;
                r_wp       <= n_wp;
                r_run_left <= n_run_left;
            end else if (req_acc) begin
                r_run_left <= run_n;
            end
            if (wb_go) r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_PAGE_BYTES) begin
                    r_page_bytes <= i_cfg.data[3:0];
                end else if (i_cfg.index == CFG_PAGE_LOG2) begin
                    r_page_lg <= i_cfg.data[2:0];
                    r_rp      <= '0;
                    r_wp      <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req    <= i_req.req_type;
            r_data   <= i_req.page_data[DW-1:0];
            r_wlen   <= i_req.write_length;
            r_amount <= i_req.amount;
            r_run_n  <= run_n;
        end
        if (wb_go) begin
            r_ok     <= n_ok;
            r_dout   <= n_dout;
            r_total  <= n_total;
            r_stored <= n_cnt_c[4:0];
            r_free   <= n_free_c[4:0];
            r_last   <= n_last;
        end
    end

    orpf_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_page_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_addr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_q)
    );

    assign i_req.ready         = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.ok            = r_ok;
    assign o_rsp.page_data_out = r_dout;
    assign o_rsp.byte_total    = r_total;
    assign o_rsp.pages_stored  = r_stored;
    assign o_rsp.pages_free    = r_free;
    assign o_rsp.last          = r_last;

endmodule
